@@ rtl/irpd_pkg.sv @@
// ============================================================================
// irpd_pkg
// Shared types, constants and symbol decode for the pulse-distance IR encoder.
// ============================================================================
package irpd_pkg;

   localparam int TICK_WIDTH_DEFAULT = 15;
   localparam int NUM_TIMING_REGS    = 6;
   localparam int CSR_ADDR_W         = 5;
   localparam int CSR_DATA_W         = 32;
   localparam int CSR_INDEX_W        = 3;
   localparam int PAYLOAD_BITS       = 48;
   localparam int PAYLOAD_IDX_W      = 6;
   localparam int SYM_IDX_W          = 7;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_LEADER  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_REPEAT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ENDING  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DIVIDER = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_INVERT  = 3'd6;

   // request codes
   localparam logic CMD_DATA   = 1'b0;
   localparam logic CMD_REPEAT = 1'b1;

   // symbol positions within a frame
   localparam logic [SYM_IDX_W-1:0] SYM_FIRST_BIT_A = 7'd1;
   localparam logic [SYM_IDX_W-1:0] SYM_LAST_BIT_A  = 7'd48;
   localparam logic [SYM_IDX_W-1:0] SYM_DIVIDER     = 7'd49;
   localparam logic [SYM_IDX_W-1:0] SYM_LEADER_B    = 7'd50;
   localparam logic [SYM_IDX_W-1:0] SYM_FIRST_BIT_B = 7'd51;
   localparam logic [SYM_IDX_W-1:0] SYM_LAST_BIT_B  = 7'd98;
   localparam logic [SYM_IDX_W-1:0] SYM_ENDING_DATA = 7'd99;
   localparam logic [SYM_IDX_W-1:0] SYM_TERM_DATA   = 7'd100;
   localparam logic [SYM_IDX_W-1:0] SYM_ENDING_REP  = 7'd1;
   localparam logic [SYM_IDX_W-1:0] SYM_TERM_REP    = 7'd2;

   typedef enum logic [2:0] {
      SYM_NONE,
      SYM_LEADER,
      SYM_REPEAT,
      SYM_ZERO,
      SYM_ONE,
      SYM_ENDING,
      SYM_DIV,
      SYM_TERM
   } sym_kind_type;

   typedef struct packed {
      logic                     cmd;
      logic [SYM_IDX_W-1:0]     last_sym;
      logic [PAYLOAD_BITS-1:0]  payload;
   } req_entry_type;

   typedef struct packed {
      logic          valid;
      req_entry_type entry;
   } queue_head_type;

   // Classify symbol s of a frame.
   function automatic sym_kind_type sym_pick(input logic cmd,
                                             input logic [SYM_IDX_W-1:0] s,
                                             input logic [PAYLOAD_BITS-1:0] payload);
      logic [SYM_IDX_W-1:0] pos;
      sym_kind_type         kind;
      pos  = '0;
      kind = SYM_NONE;
      if (cmd == CMD_REPEAT) begin
         if (s == '0) begin
            kind = SYM_REPEAT;
         end else if (s == SYM_ENDING_REP) begin
            kind = SYM_ENDING;
         end else if (s == SYM_TERM_REP) begin
            kind = SYM_TERM;
         end
      end else begin
         if (s == '0 || s == SYM_LEADER_B) begin
            kind = SYM_LEADER;
         end else if (s >= SYM_FIRST_BIT_A && s <= SYM_LAST_BIT_A) begin
            pos  = SYM_LAST_BIT_A - s;
            kind = payload[pos[PAYLOAD_IDX_W-1:0]] ? SYM_ONE : SYM_ZERO;
         end else if (s == SYM_DIVIDER) begin
            kind = SYM_DIV;
         end else if (s >= SYM_FIRST_BIT_B && s <= SYM_LAST_BIT_B) begin
            pos  = SYM_LAST_BIT_B - s;
            kind = payload[pos[PAYLOAD_IDX_W-1:0]] ? SYM_ONE : SYM_ZERO;
         end else if (s == SYM_ENDING_DATA) begin
            kind = SYM_ENDING;
         end else if (s == SYM_TERM_DATA) begin
            kind = SYM_TERM;
         end
      end
      return kind;
   endfunction

endpackage

@@ rtl/irpd_if.sv @@
// ============================================================================
// irpd_req_if / irpd_rsp_if
// Valid/ready channels for frame requests and symbol-pair results.
// ============================================================================
interface irpd_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] byte_a;
   logic [7:0] byte_a_inv;
   logic [7:0] byte_b;
   logic [7:0] byte_b_inv;
   logic [7:0] byte_c;
   logic [7:0] byte_c_inv;

   modport source (output valid, cmd, byte_a, byte_a_inv, byte_b, byte_b_inv,
                   byte_c, byte_c_inv, input ready);
   modport sink   (input valid, cmd, byte_a, byte_a_inv, byte_b, byte_b_inv,
                   byte_c, byte_c_inv, output ready);
endinterface

interface irpd_rsp_if #(
   parameter int TICK_WIDTH = 15
);
   logic                  valid;
   logic                  ready;
   logic                  s1_mark_level;
   logic [TICK_WIDTH-1:0] s1_mark_ticks;
   logic                  s1_space_level;
   logic [TICK_WIDTH-1:0] s1_space_ticks;
   logic                  s2_mark_level;
   logic [TICK_WIDTH-1:0] s2_mark_ticks;
   logic                  s2_space_level;
   logic [TICK_WIDTH-1:0] s2_space_ticks;
   logic                  s2_valid;
   logic                  last_result;

   modport source (output valid, s1_mark_level, s1_mark_ticks, s1_space_level,
                   s1_space_ticks, s2_mark_level, s2_mark_ticks, s2_space_level,
                   s2_space_ticks, s2_valid, last_result, input ready);
   modport sink   (input valid, s1_mark_level, s1_mark_ticks, s1_space_level,
                   s1_space_ticks, s2_mark_level, s2_mark_ticks, s2_space_level,
                   s2_space_ticks, s2_valid, last_result, output ready);
endinterface

@@ rtl/ir_pulse_distance_frame_encoder_core.sv @@
// ============================================================================
// ir_pulse_distance_frame_encoder_core
// Pulse-distance IR frame encoder: frame requests in, mark/space pairs out.
// ============================================================================
// A taken request is queued, then the head frame loads the result register.
// Throughput: one result per cycle while the sink is ready; a data frame gives
// 51 results, a repeat frame 2, as the sequencer steps two symbols per result.
// Frames run back to back; the two-entry request queue takes new items meanwhile.
// Reset: synchronous, active high; clears the queue pointers, the sequencer, the
// result valid and the configuration registers; result data holds until loaded.
module ir_pulse_distance_frame_encoder_core
   import irpd_pkg::*;
#(
   parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   irpd_req_if.sink              req_chan,
   irpd_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // timing registers as seen by the sequencer
   logic [NUM_TIMING_REGS-1:0][2*TICK_WIDTH-1:0] timing;
   logic                                         invert;

   // queue head and pop between front and back
   queue_head_type head;
   logic           pop;

   irpd_csr #(
      .TICK_WIDTH(TICK_WIDTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .timing      (timing),
      .invert      (invert)
   );

   // Front: take the item, tag its frame length, queue it.
   irpd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .pop      (pop),
      .head     (head)
   );

   // Back: walk the head frame two symbols per result into the output register;
   // pop the queue on the final result so the next frame follows directly.
   irpd_back #(
      .TICK_WIDTH(TICK_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .timing   (timing),
      .invert   (invert),
      .rsp_chan (rsp_chan)
   );

`ifndef SYNTHESIS
   // The final result of a frame always has an empty second slot.
   a_last_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.last_result |-> !rsp_chan.s2_valid)
      else $error("last result carries a second symbol");

   // Only the final result has an empty second slot.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.s2_valid |-> rsp_chan.last_result)
      else $error("empty second slot before end of frame");

   // An empty second slot carries all-zero fields.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.s2_valid |->
      (rsp_chan.s2_mark_ticks == '0) && (rsp_chan.s2_space_ticks == '0) &&
      !rsp_chan.s2_mark_level && !rsp_chan.s2_space_level)
      else $error("empty second slot not cleared");

   // Nothing is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");
`endif

endmodule

@@ rtl/irpd_csr.sv @@
// ============================================================================
// irpd_csr
// APB-style register file: six timing registers and the level invert bit.
// ============================================================================
module irpd_csr
   import irpd_pkg::*;
#(
   parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [NUM_TIMING_REGS-1:0][2*TICK_WIDTH-1:0] timing,
   output logic                  invert
);

   localparam int REG_W = 2 * TICK_WIDTH;

   logic [NUM_TIMING_REGS-1:0][REG_W-1:0] timing_ff;
   logic                                  invert_ff;
   logic [CSR_INDEX_W-1:0]                index;
   logic                                  wr_en;

   assign index      = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff <= '0;
         invert_ff <= 1'b0;
      end else if (wr_en) begin
         if (index == REG_INVERT) begin
            invert_ff <= csr_pwdata[0];
         end else if (index < REG_INVERT) begin
            timing_ff[index] <= csr_pwdata[REG_W-1:0];
         end
      end
   end

   always_comb begin
      case (index)
         REG_LEADER:  csr_prdata = CSR_DATA_W'(timing_ff[REG_LEADER]);
         REG_REPEAT:  csr_prdata = CSR_DATA_W'(timing_ff[REG_REPEAT]);
         REG_ZERO:    csr_prdata = CSR_DATA_W'(timing_ff[REG_ZERO]);
         REG_ONE:     csr_prdata = CSR_DATA_W'(timing_ff[REG_ONE]);
         REG_ENDING:  csr_prdata = CSR_DATA_W'(timing_ff[REG_ENDING]);
         REG_DIVIDER: csr_prdata = CSR_DATA_W'(timing_ff[REG_DIVIDER]);
         REG_INVERT:  csr_prdata = CSR_DATA_W'(invert_ff);
         default:     csr_prdata = '0;
      endcase
   end

   assign timing = timing_ff;
   assign invert = invert_ff;

endmodule

@@ rtl/irpd_front.sv @@
// ============================================================================
// irpd_front
// Request intake: classify the frame and hold it in a two-entry queue.
// ============================================================================
module irpd_front
   import irpd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   irpd_req_if.sink       req_chan,
   input  logic           pop,
   output queue_head_type head
);

   localparam int DEPTH = 2;

   req_entry_type        entry_ff [DEPTH];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 push;
   logic                 do_pop;
   req_entry_type        new_entry;

   assign req_chan.ready = (count_ff != 2'(DEPTH));
   assign push           = req_chan.valid && req_chan.ready;
   assign do_pop         = pop && (count_ff != '0);

   // classify: repeat frames end at the third symbol, data frames at the 101st
   always_comb begin
      new_entry.cmd      = req_chan.cmd;
      new_entry.last_sym = (req_chan.cmd == CMD_REPEAT) ? SYM_TERM_REP : SYM_TERM_DATA;
      new_entry.payload  = {req_chan.byte_a, req_chan.byte_a_inv, req_chan.byte_b,
                            req_chan.byte_b_inv, req_chan.byte_c, req_chan.byte_c_inv};
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = entry_ff[rd_ptr_ff];

endmodule

@@ rtl/irpd_back.sv @@
// ============================================================================
// irpd_back
// Symbol sequencer: walk the queued frame two symbols per result.
// ============================================================================
module irpd_back
   import irpd_pkg::*;
#(
   parameter int TICK_WIDTH = TICK_WIDTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_head_type head,
   output logic           pop,
   input  logic [NUM_TIMING_REGS-1:0][2*TICK_WIDTH-1:0] timing,
   input  logic           invert,
   irpd_rsp_if.source     rsp_chan
);

   localparam int REG_W = 2 * TICK_WIDTH;

   logic [SYM_IDX_W-1:0]  sym_ff, sym_in;
   logic                  valid_ff, valid_in;
   logic                  advance;
   logic                  last;
   sym_kind_type          kind1, kind2;
   logic [REG_W-1:0]      reg1, reg2;
   logic                  live1, live2;

   logic                  s1_mark_level_ff, s1_space_level_ff;
   logic [TICK_WIDTH-1:0] s1_mark_ticks_ff, s1_space_ticks_ff;
   logic                  s2_mark_level_ff, s2_space_level_ff;
   logic [TICK_WIDTH-1:0] s2_mark_ticks_ff, s2_space_ticks_ff;
   logic                  s2_valid_ff, last_ff;

   function automatic logic [REG_W-1:0] pick_reg(input sym_kind_type kind);
      logic [REG_W-1:0] r;
      case (kind)
         SYM_LEADER: r = timing[REG_LEADER];
         SYM_REPEAT: r = timing[REG_REPEAT];
         SYM_ZERO:   r = timing[REG_ZERO];
         SYM_ONE:    r = timing[REG_ONE];
         SYM_ENDING: r = timing[REG_ENDING];
         SYM_DIV:    r = timing[REG_DIVIDER];
         default:    r = '0;
      endcase
      return r;
   endfunction

   assign advance = head.valid && (!valid_ff || rsp_chan.ready);
   assign last    = (sym_ff == head.entry.last_sym);
   assign pop     = advance && last;

   always_comb begin
      kind1 = sym_pick(head.entry.cmd, sym_ff, head.entry.payload);
      kind2 = sym_pick(head.entry.cmd, sym_ff + 7'd1, head.entry.payload);
      reg1  = pick_reg(kind1);
      reg2  = pick_reg(kind2);
      live1 = (kind1 != SYM_NONE) && (kind1 != SYM_TERM);
      live2 = (kind2 != SYM_NONE) && (kind2 != SYM_TERM);
   end

   always_comb begin
      sym_in   = sym_ff;
      valid_in = valid_ff;
      if (advance) begin
         sym_in   = last ? '0 : sym_ff + 7'd2;
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sym_ff   <= sym_in;
         valid_ff <= valid_in;
      end
   end

   // result register: load on advance, hold otherwise
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_mark_level_ff  <= live1 && !invert;
         s1_space_level_ff <= live1 && invert;
         s1_mark_ticks_ff  <= reg1[REG_W-1:TICK_WIDTH];
         s1_space_ticks_ff <= reg1[TICK_WIDTH-1:0];
         s2_mark_level_ff  <= live2 && !invert;
         s2_space_level_ff <= live2 && invert;
         s2_mark_ticks_ff  <= reg2[REG_W-1:TICK_WIDTH];
         s2_space_ticks_ff <= reg2[TICK_WIDTH-1:0];
         s2_valid_ff       <= (kind2 != SYM_NONE);
         last_ff           <= last;
      end
   end

   assign rsp_chan.valid          = valid_ff;
   assign rsp_chan.s1_mark_level  = s1_mark_level_ff;
   assign rsp_chan.s1_mark_ticks  = s1_mark_ticks_ff;
   assign rsp_chan.s1_space_level = s1_space_level_ff;
   assign rsp_chan.s1_space_ticks = s1_space_ticks_ff;
   assign rsp_chan.s2_mark_level  = s2_mark_level_ff;
   assign rsp_chan.s2_mark_ticks  = s2_mark_ticks_ff;
   assign rsp_chan.s2_space_level = s2_space_level_ff;
   assign rsp_chan.s2_space_ticks = s2_space_ticks_ff;
   assign rsp_chan.s2_valid       = s2_valid_ff;
   assign rsp_chan.last_result    = last_ff;

endmodule
